FILE: rtl/ucdhs_pkg.sv
// shared types and constants of the boot-hid configuration descriptor scanner
package ucdhs_pkg;

   localparam int unsigned HEAD_BYTES = 8;
   localparam int unsigned CONFIG_POS = 5;

   localparam logic [7:0] TYPE_INTERFACE = 8'd4;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
   localparam logic [7:0] HID_CLASS      = 8'd3;
   localparam logic [7:0] BOOT_SUBCLASS  = 8'd1;
   localparam logic [7:0] PROTO_KEYBOARD = 8'd1;
   localparam logic [7:0] PROTO_MOUSE    = 8'd2;
   localparam logic [7:0] IF_MIN_LEN     = 8'd8;
   localparam logic [7:0] EP_MIN_LEN     = 8'd7;
   localparam logic [1:0] XFER_INTERRUPT = 2'b11;
   localparam logic [15:0] MPS_MASK      = 16'h07FF;

   typedef logic [HEAD_BYTES-1:0][7:0] head_type;

   typedef struct packed {
      logic        is_interface;
      logic        hid_ok;
      logic        match;
      logic [7:0]  endpoint_address;
      logic [10:0] max_packet_size;
      logic [7:0]  poll_interval;
   } judge_type;

endpackage

FILE: rtl/ucdhs_if.sv
// valid/ready channel interfaces for descriptor bytes and scan results

interface ucdhs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ucdhs_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  config_id;
   logic [7:0]  iface_id;
   logic [7:0]  boot_protocol;
   logic [7:0]  endpoint_address;
   logic [10:0] max_packet_size;
   logic [7:0]  poll_interval;

   modport source (output valid, output found, output config_id,
                   output iface_id, output boot_protocol,
                   output endpoint_address, output max_packet_size,
                   output poll_interval, input ready);
   modport sink   (input valid, input found, input config_id,
                   input iface_id, input boot_protocol,
                   input endpoint_address, input max_packet_size,
                   input poll_interval, output ready);
endinterface

FILE: rtl/usb_config_descriptor_hid_scanner.sv
// top level: walks a configuration descriptor set and reports the boot-hid interrupt-in endpoint
//
// Descriptor bytes come in on req_ch one per transfer, the final byte flagged by last; one
// result leaves on rsp_ch per set: found=1 with the captured fields at the end of the first
// interrupt-in endpoint of a boot keyboard or mouse interface, otherwise found=0 at the last
// byte. Each byte lands in an input register; the walk counters and the descriptor head are
// updated from it, and a result goes to the output register. Bytes flow at one per cycle
// while results are taken; a pending result only holds back a byte that would itself
// produce one. Bytes past MAX_BYTES in a set are ignored except for their last flag.
// There is no clearing pass after reset.
module usb_config_descriptor_hid_scanner #(
   parameter int unsigned MAX_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   ucdhs_req_if.sink   req_ch,
   ucdhs_rsp_if.source rsp_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
   localparam int unsigned POS_W = (CNT_W > 9) ? CNT_W : 9;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_adv;

   // walk state
   logic [POS_W-1:0]    byte_count_ff, byte_count_in;
   logic [POS_W-1:0]    next_start_ff, next_start_in;
   ucdhs_pkg::head_type head_ff, head_in;
   logic                hid_ff, hid_in;
   logic                stopped_ff, stopped_in;
   logic                sent_ff, sent_in;
   logic [7:0]          cfg_ff, cfg_in;
   logic [7:0]          ifnum_ff, ifnum_in;
   logic [7:0]          proto_ff, proto_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff;
   logic [7:0]  config_id_ff, iface_id_ff, boot_protocol_ff;
   logic [7:0]  endpoint_address_ff, poll_interval_ff;
   logic [10:0] max_packet_size_ff;

   logic                 in_range, walk_en, off_lt8, zero_stop;
   logic                 close_long, close_one, match_now, emit;
   logic [POS_W-1:0]     off_full;
   logic [2:0]           off_idx;
   ucdhs_pkg::head_type  view;
   logic [7:0]           dlen;
   ucdhs_pkg::judge_type verdict;

   ucdhs_judge u_judge (
      .head       (view),
      .dlen       (dlen),
      .hid_active (hid_ff),
      .verdict    (verdict)
   );

   always_comb begin
      in_range = byte_count_ff < POS_W'(MAX_BYTES);
      walk_en  = s1_valid_ff && in_range && (byte_count_ff != '0) && !sent_ff
                 && !stopped_ff && (byte_count_ff >= next_start_ff);
      off_full = byte_count_ff - next_start_ff;
      off_lt8  = off_full < POS_W'(ucdhs_pkg::HEAD_BYTES);
      off_idx  = off_full[2:0];

      // head as seen with the current byte in place
      view = head_ff;
      if (off_lt8) begin
         view[off_idx] = s1_byte_ff;
      end
      dlen       = view[0];
      zero_stop  = (off_full == '0) && (s1_byte_ff == 8'd0);
      close_long = (dlen >= 8'd2) && ((off_full + 1'b1) == POS_W'(dlen));
      // a one-byte descriptor ends at its type byte, which also opens the next one
      close_one  = (dlen == 8'd1) && (off_full == POS_W'(1));
      match_now  = walk_en && !zero_stop && close_long && verdict.match;
      emit       = s1_valid_ff && (match_now || (s1_last_ff && !sent_ff));
      s1_adv     = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ch.ready);

      byte_count_in = byte_count_ff;
      next_start_in = next_start_ff;
      head_in       = head_ff;
      hid_in        = hid_ff;
      stopped_in    = stopped_ff;
      sent_in       = sent_ff;
      cfg_in        = cfg_ff;
      ifnum_in      = ifnum_ff;
      proto_in      = proto_ff;

      if (s1_valid_ff && in_range) begin
         byte_count_in = byte_count_ff + 1'b1;
         if (byte_count_ff == '0) begin
            next_start_in = POS_W'(s1_byte_ff);
            if (s1_byte_ff == 8'd0) begin
               stopped_in = 1'b1;
            end
         end
         if (byte_count_ff == POS_W'(ucdhs_pkg::CONFIG_POS)) begin
            cfg_in = s1_byte_ff;
         end
      end

      if (walk_en) begin
         if (zero_stop) begin
            stopped_in = 1'b1;
         end else if (close_long) begin
            next_start_in = next_start_ff + POS_W'(dlen);
            if (verdict.is_interface) begin
               hid_in = verdict.hid_ok;
               if (verdict.hid_ok) begin
                  ifnum_in = view[2];
                  proto_in = view[7];
               end
            end
            if (verdict.match) begin
               sent_in    = 1'b1;
               stopped_in = 1'b1;
            end
         end else if (close_one) begin
            next_start_in = next_start_ff + 1'b1;
            if (verdict.is_interface) begin
               hid_in = 1'b0;
            end
            head_in[0] = s1_byte_ff;
            if (s1_byte_ff == 8'd0) begin
               stopped_in = 1'b1;
            end
         end else if (off_lt8) begin
            head_in[off_idx] = s1_byte_ff;
         end
      end

      // end of set returns the walk to its reset state
      if (s1_valid_ff && s1_last_ff) begin
         byte_count_in = '0;
         next_start_in = '0;
         hid_in        = 1'b0;
         stopped_in    = 1'b0;
         sent_in       = 1'b0;
         cfg_in        = 8'd0;
         ifnum_in      = 8'd0;
         proto_in      = 8'd0;
      end

      s1_valid_in = req_ch.valid || (s1_valid_ff && !s1_adv);

      if (s1_adv && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ch.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_count_ff <= '0;
         next_start_ff <= '0;
         hid_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         sent_ff       <= 1'b0;
         cfg_ff        <= 8'd0;
         ifnum_ff      <= 8'd0;
         proto_ff      <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            byte_count_ff <= byte_count_in;
            next_start_ff <= next_start_in;
            hid_ff        <= hid_in;
            stopped_ff    <= stopped_in;
            sent_ff       <= sent_in;
            cfg_ff        <= cfg_in;
            ifnum_ff      <= ifnum_in;
            proto_ff      <= proto_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_last_ff <= req_ch.last;
      end
      if (s1_adv) begin
         head_ff <= head_in;
      end
      if (s1_adv && emit) begin
         found_ff <= match_now;
         if (match_now) begin
            // header byte five may arrive with this very byte
            config_id_ff        <= (byte_count_ff == POS_W'(ucdhs_pkg::CONFIG_POS))
                                   ? s1_byte_ff : cfg_ff;
            iface_id_ff         <= ifnum_ff;
            boot_protocol_ff    <= proto_ff;
            endpoint_address_ff <= verdict.endpoint_address;
            max_packet_size_ff  <= verdict.max_packet_size;
            poll_interval_ff    <= verdict.poll_interval;
         end else begin
            config_id_ff        <= 8'd0;
            iface_id_ff         <= 8'd0;
            boot_protocol_ff    <= 8'd0;
            endpoint_address_ff <= 8'd0;
            max_packet_size_ff  <= 11'd0;
            poll_interval_ff    <= 8'd0;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.found            = found_ff;
   assign rsp_ch.config_id        = config_id_ff;
   assign rsp_ch.iface_id         = iface_id_ff;
   assign rsp_ch.boot_protocol    = boot_protocol_ff;
   assign rsp_ch.endpoint_address = endpoint_address_ff;
   assign rsp_ch.max_packet_size  = max_packet_size_ff;
   assign rsp_ch.poll_interval    = poll_interval_ff;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !(s1_adv && emit))
      else $error("result register overwritten while stalled");

   // once an endpoint is reported the walk is frozen
   a_sent_stops: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> stopped_ff)
      else $error("walk still running after a reported endpoint");

   // a found transfer inside a set locks out further results
   a_match_locks: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && match_now && !s1_last_ff) |=> sent_ff)
      else $error("match did not set the sent flag");

   // the last byte returns the walk to its start
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (byte_count_ff == '0 && !sent_ff && !stopped_ff))
      else $error("walk state not cleared after the last byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= POS_W'(MAX_BYTES))
      else $error("byte count past its limit");

endmodule

FILE: rtl/ucdhs_judge.sv
// decision on one completed descriptor: boot-hid interface or interrupt-in endpoint
module ucdhs_judge (
   input  ucdhs_pkg::head_type  head,
   input  logic [7:0]           dlen,
   input  logic                 hid_active,
   output ucdhs_pkg::judge_type verdict
);

   logic [7:0]  dtype;
   logic [15:0] mps_raw;

   always_comb begin
      dtype   = head[1];
      mps_raw = {head[5], head[4]} & ucdhs_pkg::MPS_MASK;

      verdict.is_interface = (dtype == ucdhs_pkg::TYPE_INTERFACE);
      verdict.hid_ok = verdict.is_interface
                       && (dlen >= ucdhs_pkg::IF_MIN_LEN)
                       && (head[5] == ucdhs_pkg::HID_CLASS)
                       && (head[6] == ucdhs_pkg::BOOT_SUBCLASS)
                       && (head[7] inside {ucdhs_pkg::PROTO_KEYBOARD,
                                           ucdhs_pkg::PROTO_MOUSE});
      verdict.match = (dtype == ucdhs_pkg::TYPE_ENDPOINT) && hid_active
                      && (dlen >= ucdhs_pkg::EP_MIN_LEN)
                      && head[2][7]
                      && (head[3][1:0] == ucdhs_pkg::XFER_INTERRUPT);
      verdict.endpoint_address = head[2];
      verdict.max_packet_size  = mps_raw[10:0];
      verdict.poll_interval    = head[6];
   end

endmodule
